>>> rtl/ipsa_pkg.sv
// Shared types, constants and helper functions for the IPS patch stream applier.
// Used by every module of the block; depends on nothing else.

package ipsa_pkg;

  // Field widths
  localparam int unsigned TSIZE_W = 26;
  localparam int unsigned ADDR_W  = 25;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned RUN_W   = 16;

  // Patch format limits and markers
  localparam int unsigned MAX_PATCH_BYTES = 16777216;
  localparam int unsigned HDR_LEN         = 5;
  localparam int unsigned MIN_PATCH       = 9;
  localparam logic [ACC_W-1:0]   EOF_MARK          = 24'h454F46;
  localparam logic [TSIZE_W-1:0] TARGET_SIZE_RESET = 26'd16777216;

  // Result queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OFFSET,
    PH_LENGTH,
    PH_RCOUNT,
    PH_RVALUE,
    PH_LITERAL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FILL,
    KIND_DONE,
    KIND_FAIL
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_BAD_HEADER,
    CAUSE_BAD_LENGTH,
    CAUSE_PAST_END,
    CAUSE_TRUNCATED,
    CAUSE_ZERO_TARGET
  } cause_t;

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       end_of_patch;
  } patch_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data_value;
    logic [RUN_W-1:0]  fill_count;
    cause_t            fail_cause;
    logic              last_of_item;
  } result_t;

  // Results produced by one accepted byte, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Expected header byte for a given position of "PATCH"
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic result_t make_result(
    input kind_t             k,
    input logic [ADDR_W-1:0] addr,
    input logic [7:0]        data,
    input logic [RUN_W-1:0]  cnt,
    input cause_t            cause
  );
    result_t r;
    r.kind         = k;
    r.address      = addr;
    r.data_value   = data;
    r.fill_count   = cnt;
    r.fail_cause   = cause;
    r.last_of_item = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/ipsa_parser.sv
// Patch parser: header check, record field assembly, clipping and failure detection.
// Holds the parse state and the target size register; depends on ipsa_pkg.

module ipsa_parser
  import ipsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  patch_t             patch,
  input  logic               cfg_we,
  input  logic [TSIZE_W-1:0] cfg_data,
  output push_t              push
);

  phase_t               phase, phase_next;
  logic [2:0]           idx, idx_next;
  logic [ACC_W-1:0]     acc, acc_next;
  logic [ADDR_W-1:0]    wp, wp_next;
  logic [RUN_W-1:0]     br, br_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic                 finished, finished_next;
  logic [TSIZE_W-1:0]   tsize;

  logic [COUNT_W-1:0]   cnt_inc;
  logic [2:0]           idx_inc;
  logic [ACC_W-1:0]     acc_off;
  logic [RUN_W-1:0]     acc_len;
  logic [TSIZE_W-1:0]   wp_ext;
  logic [TSIZE_W-1:0]   avail;
  logic [RUN_W-1:0]     br_dec;
  logic                 rearm;
  logic                 b_end;
  logic [7:0]           b;
  logic [1:0]           n;
  result_t              res [2];

  assign b       = patch.patch_byte;
  assign b_end   = patch.end_of_patch;
  assign cnt_inc = count + 1'b1;
  assign idx_inc = idx + 1'b1;
  assign acc_off = {acc[15:0], b};
  assign acc_len = {acc[7:0], b};
  assign wp_ext  = {1'b0, wp};
  assign avail   = tsize - wp_ext;
  assign br_dec  = (br != '0) ? br - 1'b1 : br;

  // Work out the next parse state and the results of this byte
  always_comb begin
    phase_next    = phase;
    idx_next      = idx;
    acc_next      = acc;
    wp_next       = wp;
    br_next       = br;
    count_next    = count;
    finished_next = finished;
    rearm         = 1'b0;
    n             = 2'd0;
    res[0] = make_result(KIND_DONE, '0, '0, '0, CAUSE_BAD_HEADER);
    res[1] = make_result(KIND_DONE, '0, '0, '0, CAUSE_BAD_HEADER);

    if (accept) begin
      if (finished) begin
        // drop bytes up to the end of the current patch
        rearm = b_end;
      end else begin
        if (count == '0 && tsize == '0) begin
          res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_ZERO_TARGET);
          n = 2'd1;
          finished_next = 1'b1;
        end else begin
          count_next = cnt_inc;
          if (cnt_inc > COUNT_W'(MAX_PATCH_BYTES) ||
              (b_end && cnt_inc < COUNT_W'(MIN_PATCH))) begin
            res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_BAD_LENGTH);
            n = 2'd1;
            finished_next = 1'b1;
          end else begin
            case (phase)
              PH_HEADER: begin
                if (idx >= 3'(HDR_LEN) || b != header_byte(idx)) begin
                  res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_BAD_HEADER);
                  n = 2'd1;
                  finished_next = 1'b1;
                end else if (idx_inc == 3'(HDR_LEN)) begin
                  phase_next = PH_OFFSET;
                  idx_next   = '0;
                  acc_next   = '0;
                end else begin
                  idx_next = idx_inc;
                end
              end
              PH_OFFSET: begin
                acc_next = acc_off;
                idx_next = idx_inc;
                if (idx_inc >= 3'd3) begin
                  if (acc_off == EOF_MARK) begin
                    res[0] = make_result(KIND_DONE, '0, '0, '0, CAUSE_BAD_HEADER);
                    n = 2'd1;
                    finished_next = 1'b1;
                  end else begin
                    wp_next    = {1'b0, acc_off};
                    phase_next = PH_LENGTH;
                    idx_next   = '0;
                    acc_next   = '0;
                  end
                end
              end
              PH_LENGTH, PH_RCOUNT: begin
                acc_next = {8'h00, acc_len};
                idx_next = idx_inc;
                if (idx_inc >= 3'd2) begin
                  idx_next = '0;
                  acc_next = '0;
                  if (phase == PH_RCOUNT) begin
                    br_next    = acc_len;
                    phase_next = PH_RVALUE;
                  end else if (acc_len == '0) begin
                    phase_next = PH_RCOUNT;
                  end else begin
                    br_next    = acc_len;
                    phase_next = PH_LITERAL;
                  end
                end
              end
              PH_RVALUE: begin
                if (br != '0) begin
                  if (wp_ext >= tsize) begin
                    res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_PAST_END);
                    n = 2'd1;
                    finished_next = 1'b1;
                  end else if ({10'd0, br} > avail) begin
                    // clip the run at the end of the target, then fail
                    res[0] = make_result(KIND_FILL, wp, b, avail[RUN_W-1:0],
                                         CAUSE_BAD_HEADER);
                    res[1] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_PAST_END);
                    n = 2'd2;
                    finished_next = 1'b1;
                  end else begin
                    res[0] = make_result(KIND_FILL, wp, b, br, CAUSE_BAD_HEADER);
                    n = 2'd1;
                  end
                end
                br_next    = '0;
                phase_next = PH_OFFSET;
                idx_next   = '0;
                acc_next   = '0;
              end
              PH_LITERAL: begin
                if (wp_ext >= tsize) begin
                  res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_PAST_END);
                  n = 2'd1;
                  finished_next = 1'b1;
                end else begin
                  res[0] = make_result(KIND_WRITE, wp, b, RUN_W'(1), CAUSE_BAD_HEADER);
                  n = 2'd1;
                  wp_next = wp + 1'b1;
                  br_next = br_dec;
                  if (br_dec == '0) begin
                    phase_next = PH_OFFSET;
                    idx_next   = '0;
                    acc_next   = '0;
                  end
                end
              end
              default: begin
                res[0] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_TRUNCATED);
                n = 2'd1;
                finished_next = 1'b1;
              end
            endcase

            // close the patch on its final byte
            if (!finished_next && b_end) begin
              if (phase_next == PH_OFFSET && idx_next == '0) begin
                res[n[0]] = make_result(KIND_DONE, '0, '0, '0, CAUSE_BAD_HEADER);
              end else begin
                res[n[0]] = make_result(KIND_FAIL, '0, '0, '0, CAUSE_TRUNCATED);
              end
              n = n + 2'd1;
              finished_next = 1'b1;
            end
          end
        end
        rearm = finished_next && b_end;
      end
    end

    // start afresh for the next patch
    if (rearm) begin
      phase_next    = PH_HEADER;
      idx_next      = '0;
      acc_next      = '0;
      wp_next       = '0;
      br_next       = '0;
      count_next    = '0;
      finished_next = 1'b0;
    end

    // mark the final result of this byte
    if (n == 2'd1) begin
      res[0].last_of_item = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_item = 1'b1;
    end
  end

  assign push.count  = n;
  assign push.first  = res[0];
  assign push.second = res[1];

  // Hold parse state and target size
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      idx      <= '0;
      acc      <= '0;
      wp       <= '0;
      br       <= '0;
      count    <= '0;
      finished <= 1'b0;
      tsize    <= TARGET_SIZE_RESET;
    end else begin
      phase    <= phase_next;
      idx      <= idx_next;
      acc      <= acc_next;
      wp       <= wp_next;
      br       <= br_next;
      count    <= count_next;
      finished <= finished_next;
      if (cfg_we) begin
        tsize <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/ipsa_result_queue.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
// Parts the parser from the output channel; depends on ipsa_pkg.

module ipsa_result_queue
  import ipsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_plus;

  assign pop          = result_valid && !result_stall;
  assign wr_ptr_plus  = wr_ptr + 1'b1;
  assign result_valid = (count != '0);
  assign result       = entries[rd_ptr];
  // stall the input unless two free slots remain
  assign full         = (count > CNT_W'(QUEUE_DEPTH - 2));

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.second;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

>>> rtl/ips_patch_stream_applier.sv
// Top level of the IPS patch stream applier.
// Instantiates ipsa_parser and ipsa_result_queue; depends on ipsa_pkg.
//
// Usage:
//   patch channel  : one patch byte per beat (patch_valid / patch_stall), with
//                    end_of_patch set on the last byte of each patch.
//   result channel : write, fill, done and fail results (result_valid /
//                    result_stall); last_of_item marks the last result of a byte.
//   cfg channel    : writes target_size (cfg_valid / cfg_ready); always ready.
// Timing:
//   Each byte is parsed in the cycle it is accepted; its results are registered
//   in the result queue behind any still held. One byte per cycle is taken as
//   long as the four-entry result queue has room for two more results, so the
//   sustained rate is one byte per cycle, limited only by the single read port
//   of the result queue when bytes make two results or the receiver stalls.
// Reset:
//   rst clears the parser to wait for a header, empties the queue and sets
//   target_size to 16777216. A stalled receiver fills the queue, and
//   patch_stall rises once fewer than two entries are free, until it drains.

module ips_patch_stream_applier
  import ipsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               patch_valid,
  output logic               patch_stall,
  input  patch_t             patch,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TSIZE_W-1:0] cfg_data
);

  logic  accept;
  logic  full;
  push_t push;

  assign cfg_ready   = 1'b1;
  assign patch_stall = full;
  assign accept      = patch_valid && !patch_stall;

  ipsa_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .patch    (patch),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push)
  );

  ipsa_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/ipsa_port_checker.sv
// Port-level checks for the IPS patch stream applier, bound to the top level.
// Depends on ipsa_pkg and ips_patch_stream_applier.

module ipsa_port_checker
  import ipsa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    patch_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Reset empties the block
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !patch_stall)
    else $error("block not empty after reset");

  // Writes carry one byte, fills at least one
  a_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_WRITE || result.kind == KIND_FILL) |->
      (result.fill_count != '0) &&
      (result.kind != KIND_WRITE || result.fill_count == 16'd1))
    else $error("bad fill_count on write or fill");

  // Done and fail always close the byte's results
  a_close: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_DONE || result.kind == KIND_FAIL) |->
      result.last_of_item)
    else $error("done or fail not last of item");

endmodule

bind ips_patch_stream_applier ipsa_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .patch_stall  (patch_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
